### sv/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared types, codes and the per-command field table of the token parser.
// ----------------------------------------------------------------------------
package ttp_pkg;

    localparam int MAX_FIELDS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 8;

    // result queue between parser and output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // input actions
    localparam logic [1:0] ACT_TOKEN = 2'd0;
    localparam logic [1:0] ACT_EOL   = 2'd1;
    localparam logic [1:0] ACT_AUTH  = 2'd2;
    localparam logic [1:0] ACT_STORE = 2'd3;

    // token kinds
    localparam logic [1:0] TK_HASH = 2'd0;
    localparam logic [1:0] TK_BAR  = 2'd1;

    // commands
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_L    = 3'd1;
    localparam logic [2:0] CMD_D    = 3'd2;
    localparam logic [2:0] CMD_P    = 3'd3;
    localparam logic [2:0] CMD_SD   = 3'd4;
    localparam logic [2:0] CMD_B    = 3'd5;
    localparam logic [2:0] CMD_M    = 3'd6;
    localparam logic [2:0] CMD_I    = 3'd7;

    // result events
    localparam logic [2:0] EV_STORE  = 3'd0;
    localparam logic [2:0] EV_START  = 3'd1;
    localparam logic [2:0] EV_SUBMIT = 3'd2;
    localparam logic [2:0] EV_AUTH   = 3'd3;
    localparam logic [2:0] EV_REPLY  = 3'd4;

    // reply codes
    localparam logic [2:0] RC_ONE       = 3'd0;
    localparam logic [2:0] RC_ZERO      = 3'd1;
    localparam logic [2:0] RC_ZERO_ONE  = 3'd2;
    localparam logic [2:0] RC_MINUS_ONE = 3'd3;
    localparam logic [2:0] RC_EMPTY     = 3'd4;
    localparam logic [2:0] RC_COUNT     = 3'd5;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  field_slot;
        logic [15:0] field_ref;
        logic [2:0]  reply_cmd;
        logic [2:0]  reply_code;
        logic [7:0]  reply_count;
        logic        last;
    } ev_t;

    // number of fields a command carries
    function automatic logic [4:0] field_count(input logic [2:0] cmd, input logic [4:0] mf);
        logic [4:0] n;
        case (cmd)
            CMD_L:        n = 5'd2;
            CMD_D, CMD_B: n = mf;
            CMD_SD:       n = 5'd10;
            CMD_M:        n = 5'd1;
            CMD_I:        n = 5'd6;
            default:      n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/telematics_token_parser_top.sv
// ----------------------------------------------------------------------------
// telematics_token_parser_top
// Token-level parser for '#cmd#f1;f2|...CRLF' telemetry lines.
// ----------------------------------------------------------------------------
// Output: results of an item are written to the result queue when it is
//   accepted and appear on the result side in the next cycle, as empty drops.
// Throughput: one item per cycle while full is low; each item makes zero to
//   two results, and the output side drains one per cycle, so the 4-entry
//   result queue sets full whenever fewer than two entries are free.
// Reset: rst_n clears the parse state, flags, record count and queue at once.
// ----------------------------------------------------------------------------
module telematics_token_parser_top #(
    parameter int MAX_FIELDS  = ttp_pkg::MAX_FIELDS_DEF,
    parameter int COUNT_WIDTH = ttp_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // item side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [1:0]  token_kind,
    input  logic [2:0]  command_code,
    input  logic [15:0] token_ref,
    input  logic        result_ok,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic [3:0]  field_slot,
    output logic [15:0] field_ref,
    output logic [2:0]  reply_cmd,
    output logic [2:0]  reply_code,
    output logic [7:0]  reply_count,
    output logic        last
);
    import ttp_pkg::*;

    logic       accept;
    logic       rd;
    ev_t        ev0, ev1, head;
    logic [1:0] ev_cnt;

    // an item goes in whenever the queue has room for two results
    assign accept = push & ~full;
    assign rd     = pop & ~empty;

    // front: parse state machine, one item per cycle while the queue is not full
    ttp_front #(
        .MAX_FIELDS  (MAX_FIELDS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .token_kind   (token_kind),
        .command_code (command_code),
        .token_ref    (token_ref),
        .result_ok    (result_ok),
        .ev0          (ev0),
        .ev1          (ev1),
        .ev_cnt       (ev_cnt)
    );

    // back: result queue, oldest result on the ports
    ttp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_cnt  (ev_cnt),
        .wr0     (ev0),
        .wr1     (ev1),
        .rd      (rd),
        .rd_data (head),
        .empty   (empty),
        .full    (full)
    );

    assign event_res   = head.event_res;
    assign field_slot  = head.field_slot;
    assign field_ref   = head.field_ref;
    assign reply_cmd   = head.reply_cmd;
    assign reply_code  = head.reply_code;
    assign reply_count = head.reply_count;
    assign last        = head.last;

endmodule

### sv/ttp_front.sv
// ----------------------------------------------------------------------------
// ttp_front
// Parser front: takes one item per cycle while accept is high, updates the
// line state and produces up to two result items for the queue.
// ----------------------------------------------------------------------------
module ttp_front #(
    parameter int MAX_FIELDS  = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    action,
    input  logic [1:0]    token_kind,
    input  logic [2:0]    command_code,
    input  logic [15:0]   token_ref,
    input  logic          result_ok,
    output ttp_pkg::ev_t  ev0,
    output ttp_pkg::ev_t  ev1,
    output logic [1:0]    ev_cnt
);
    import ttp_pkg::*;

    localparam logic [3:0] ST_INITIAL      = 4'd0;
    localparam logic [3:0] ST_COMMAND      = 4'd1;
    localparam logic [3:0] ST_BODY         = 4'd2;
    localparam logic [3:0] ST_HASH_FIRST   = 4'd3;
    localparam logic [3:0] ST_HASH_SECOND  = 4'd4;
    localparam logic [3:0] ST_BAR          = 4'd5;
    localparam logic [3:0] ST_END          = 4'd6;
    localparam logic [3:0] ST_SKIP_BAR_END = 4'd7;
    localparam logic [3:0] ST_SKIP_END     = 4'd8;

    localparam logic [4:0] MF = 5'(MAX_FIELDS);
    localparam int         EW = COUNT_WIDTH + 8;

    typedef struct packed {
        logic vld;
        ev_t  ev;
    } commit_t;

    logic [3:0]             state_reg, state_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [4:0]             fields_left_reg, fields_left_next;
    logic                   logged_in_reg, logged_in_next;
    logic                   parse_error_reg, parse_error_next;
    logic [COUNT_WIDTH-1:0] record_count_reg, record_count_next;

    logic [EW-1:0] count_ext;
    logic [7:0]    count_sat;
    logic          is_hash, is_bar;
    logic [4:0]    fl_dec;
    ev_t           evs [2];
    logic [1:0]    n_ev;
    commit_t       cm;

    function automatic ev_t mk_ev(input logic [2:0] res, input logic [3:0] slot,
                                  input logic [15:0] tref, input logic [2:0] rcode,
                                  input logic [2:0] cmd, input logic [7:0] cnt);
        ev_t e;
        e             = '0;
        e.event_res   = res;
        e.field_slot  = (res == EV_STORE) ? slot : 4'd0;
        e.field_ref   = (res == EV_STORE) ? tref : 16'd0;
        e.reply_cmd   = (res == EV_REPLY) ? cmd : 3'd0;
        e.reply_code  = (res == EV_REPLY) ? rcode : 3'd0;
        e.reply_count = (res == EV_REPLY && rcode == RC_COUNT) ? cnt : 8'd0;
        return e;
    endfunction

    // line commit: what the finished command emits
    function automatic commit_t commit_fn(input logic [2:0] cmd, input logic err,
                                          input logic [7:0] cnt);
        commit_t c;
        c = '0;
        case (cmd)
            CMD_L:
            begin
                c.vld = 1'b1;
                c.ev  = err ? mk_ev(EV_REPLY, 4'd0, 16'd0, RC_ZERO, cmd, cnt)
                            : mk_ev(EV_AUTH, 4'd0, 16'd0, RC_ONE, cmd, cnt);
            end
            CMD_D, CMD_SD, CMD_M:
            begin
                c.vld = 1'b1;
                c.ev  = mk_ev(EV_SUBMIT, 4'd0, 16'd0, RC_ONE, cmd, cnt);
            end
            CMD_P:
            begin
                c.vld = 1'b1;
                c.ev  = mk_ev(EV_REPLY, 4'd0, 16'd0, RC_EMPTY, cmd, cnt);
            end
            CMD_B:
            begin
                c.vld = 1'b1;
                c.ev  = mk_ev(EV_REPLY, 4'd0, 16'd0, RC_COUNT, cmd, cnt);
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    assign count_ext = {8'd0, record_count_reg};
    assign count_sat = (count_ext > EW'(255)) ? 8'hFF : count_ext[7:0];
    assign is_hash   = (token_kind == TK_HASH);
    assign is_bar    = (token_kind == TK_BAR);
    assign fl_dec    = fields_left_reg - 5'd1;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        fields_left_next  = fields_left_reg;
        logged_in_next    = logged_in_reg;
        parse_error_next  = parse_error_reg;
        record_count_next = record_count_reg;
        evs[0]            = '0;
        evs[1]            = '0;
        n_ev              = 2'd0;
        cm                = '0;

        if (accept)
        begin
            case (action)
                ACT_TOKEN:
                begin
                    case (state_reg)
                        ST_INITIAL:
                        begin
                            parse_error_next  = 1'b0;
                            record_count_next = '0;
                            evs[0] = mk_ev(EV_START, 4'd0, 16'd0, RC_ONE, cmd_reg, count_sat);
                            n_ev   = 2'd1;
                            state_next = ST_HASH_FIRST;
                        end
                        ST_COMMAND:
                        begin
                            if (is_hash || is_bar || command_code == CMD_NONE)
                            begin
                                state_next       = ST_SKIP_END;
                                parse_error_next = 1'b1;
                            end
                            else
                            begin
                                cmd_next         = command_code;
                                fields_left_next = field_count(command_code, MF);
                                if (!logged_in_reg && command_code != CMD_L)
                                    state_next = ST_SKIP_END;
                                else
                                    state_next = ST_HASH_SECOND;
                            end
                        end
                        ST_BODY:
                        begin
                            if (cmd_reg == CMD_B && is_bar)
                            begin
                                evs[0] = mk_ev(EV_SUBMIT, 4'd0, 16'd0, RC_ONE, cmd_reg,
                                               count_sat);
                                evs[1] = mk_ev(EV_START, 4'd0, 16'd0, RC_ONE, cmd_reg,
                                               count_sat);
                                n_ev   = 2'd2;
                                fields_left_next = MF;
                            end
                            else
                            begin
                                if (fields_left_reg != 5'd0)
                                begin
                                    fields_left_next = fl_dec;
                                    evs[0] = mk_ev(EV_STORE, fl_dec[3:0], token_ref, RC_ONE,
                                                   cmd_reg, count_sat);
                                    n_ev   = 2'd1;
                                end
                                if (fields_left_reg <= 5'd1)
                                    state_next = (cmd_reg != CMD_B) ? ST_END : ST_BAR;
                            end
                        end
                        ST_HASH_FIRST, ST_HASH_SECOND:
                        begin
                            if (is_hash)
                                state_next = (state_reg == ST_HASH_FIRST) ? ST_COMMAND
                                                                          : ST_BODY;
                            else
                            begin
                                state_next       = ST_SKIP_END;
                                parse_error_next = 1'b1;
                            end
                        end
                        ST_BAR:
                        begin
                            evs[0] = mk_ev(EV_SUBMIT, 4'd0, 16'd0, RC_ONE, cmd_reg, count_sat);
                            n_ev   = 2'd1;
                            if (is_bar)
                            begin
                                state_next = ST_BODY;
                                evs[1] = mk_ev(EV_START, 4'd0, 16'd0, RC_ONE, cmd_reg,
                                               count_sat);
                                n_ev   = 2'd2;
                                fields_left_next = MF;
                            end
                            else
                            begin
                                state_next       = ST_SKIP_BAR_END;
                                parse_error_next = 1'b1;
                            end
                        end
                        ST_SKIP_BAR_END:
                        begin
                            if (is_bar)
                            begin
                                state_next = ST_BODY;
                                evs[0] = mk_ev(EV_START, 4'd0, 16'd0, RC_ONE, cmd_reg,
                                               count_sat);
                                n_ev   = 2'd1;
                                fields_left_next = MF;
                            end
                        end
                        ST_END:
                        begin
                            state_next       = ST_SKIP_END;
                            parse_error_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
                ACT_EOL:
                begin
                    state_next = ST_INITIAL;
                    case (state_reg)
                        ST_BODY:
                        begin
                            if (cmd_reg != CMD_B)
                            begin
                                parse_error_next = 1'b1;
                                cm = commit_fn(cmd_reg, 1'b1, count_sat);
                                evs[0] = cm.ev;
                                n_ev   = {1'b0, cm.vld};
                            end
                            else
                            begin
                                cm = commit_fn(cmd_reg, parse_error_reg, count_sat);
                                evs[0] = mk_ev(EV_SUBMIT, 4'd0, 16'd0, RC_ONE, cmd_reg,
                                               count_sat);
                                evs[1] = cm.ev;
                                n_ev   = cm.vld ? 2'd2 : 2'd1;
                            end
                        end
                        ST_BAR:
                        begin
                            cm = commit_fn(cmd_reg, parse_error_reg, count_sat);
                            evs[0] = mk_ev(EV_SUBMIT, 4'd0, 16'd0, RC_ONE, cmd_reg, count_sat);
                            evs[1] = cm.ev;
                            n_ev   = cm.vld ? 2'd2 : 2'd1;
                        end
                        ST_SKIP_BAR_END, ST_END:
                        begin
                            cm = commit_fn(cmd_reg, parse_error_reg, count_sat);
                            evs[0] = cm.ev;
                            n_ev   = {1'b0, cm.vld};
                        end
                        ST_COMMAND, ST_HASH_FIRST, ST_HASH_SECOND:
                        begin
                            parse_error_next = 1'b1;
                        end
                        default:
                        begin
                            n_ev = 2'd0;
                        end
                    endcase
                end
                ACT_AUTH:
                begin
                    state_next = ST_INITIAL;
                    if (result_ok)
                        logged_in_next = 1'b1;
                    evs[0] = mk_ev(EV_REPLY, 4'd0, 16'd0, result_ok ? RC_ONE : RC_ZERO_ONE,
                                   cmd_reg, count_sat);
                    n_ev   = 2'd1;
                end
                default:
                begin
                    // record stored completion
                    if (cmd_reg == CMD_B)
                    begin
                        if (record_count_reg != {COUNT_WIDTH{1'b1}})
                            record_count_next = record_count_reg + 1'b1;
                    end
                    else
                    begin
                        evs[0] = mk_ev(EV_REPLY, 4'd0, 16'd0,
                                       result_ok ? RC_ONE :
                                       ((cmd_reg == CMD_D || cmd_reg == CMD_SD) ? RC_MINUS_ONE
                                                                                : RC_ZERO),
                                       cmd_reg, count_sat);
                        n_ev   = 2'd1;
                    end
                end
            endcase
        end

        if (n_ev == 2'd2)
            evs[1].last = 1'b1;
        else if (n_ev == 2'd1)
            evs[0].last = 1'b1;
    end

    assign ev0    = evs[0];
    assign ev1    = evs[1];
    assign ev_cnt = n_ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INITIAL;
            cmd_reg          <= CMD_NONE;
            fields_left_reg  <= '0;
            logged_in_reg    <= 1'b0;
            parse_error_reg  <= 1'b0;
            record_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            fields_left_reg  <= fields_left_next;
            logged_in_reg    <= logged_in_next;
            parse_error_reg  <= parse_error_next;
            record_count_reg <= record_count_next;
        end
    end

endmodule

### sv/ttp_queue.sv
// ----------------------------------------------------------------------------
// ttp_queue
// Result queue: takes up to two items per cycle, hands out one per cycle.
// ----------------------------------------------------------------------------
module ttp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    wr_cnt,
    input  ttp_pkg::ev_t  wr0,
    input  ttp_pkg::ev_t  wr1,
    input  logic          rd,
    output ttp_pkg::ev_t  rd_data,
    output logic          empty,
    output logic          full
);
    import ttp_pkg::*;

    ev_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1   = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(rd);
    assign count_next  = count_reg + (QPTR_W + 1)'(wr_cnt) - (QPTR_W + 1)'(rd);

    assign rd_data = slot_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    // room for a worst-case item of two results
    assign full    = (count_reg > (QPTR_W + 1)'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            slot_reg[wr_ptr_reg] <= wr0;
        if (wr_cnt == 2'd2)
            slot_reg[wr_ptr_p1] <= wr1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/ttp_checker.sv
// ----------------------------------------------------------------------------
// ttp_checker
// Port-level checks of the token parser's result items.
// ----------------------------------------------------------------------------
module ttp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  event_res,
    input logic [3:0]  field_slot,
    input logic [15:0] field_ref,
    input logic [2:0]  reply_cmd,
    input logic [2:0]  reply_code,
    input logic [7:0]  reply_count,
    input logic        last
);
    import ttp_pkg::*;

    // no result appears without an accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared with no item accepted");

    // store fields are zero on any other event
    a_store_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res != EV_STORE) |-> (field_slot == 4'd0 && field_ref == 16'd0))
        else $error("store fields set on a non-store result");

    // reply fields are zero on any other event
    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res != EV_REPLY) |-> (reply_cmd == 3'd0 && reply_code == 3'd0))
        else $error("reply fields set on a non-reply result");

    // count only shown with the record count reply
    a_count_field: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reply_count != 8'd0) |-> (event_res == EV_REPLY && reply_code == RC_COUNT))
        else $error("reply count set outside a count reply");

    // both results of an item are queued together, so a non-last result
    // always has its sibling right behind it
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> !empty)
        else $error("second result of an item missing");

endmodule

bind telematics_token_parser_top ttp_checker u_ttp_checker (.*);
